FILE: rtl/rbp_pkg.sv
package rbp_pkg;

  // Coordinate and size widths of the payload fields.
  localparam int CoordBits = 16;
  localparam int SizeBits  = 12;

  // Doubled (half-unit) coordinates, ray deltas and cross products.
  localparam int C2W   = ((CoordBits > SizeBits) ? CoordBits : SizeBits + 1) + 2;
  localparam int DW    = C2W + 1;
  localparam int PW    = SizeBits + DW;
  localparam int QBits = SizeBits;
  localparam int KW    = C2W + 1;

  typedef logic signed [C2W-1:0] c2_t;
  typedef logic signed [DW-1:0]  delta_t;
  typedef logic [DW-1:0]         mag_t;
  typedef logic [PW-1:0]         prod_t;
  typedef logic [SizeBits-1:0]   size_t;
  typedef logic signed [KW-1:0]  wide_t;

  // Side information that travels with one query through the divider.
  typedef struct packed {
    logic center_only;
    logic have;
    logic div_to_x;
    logic neg;
    c2_t  base;
    c2_t  edge_pos;
    c2_t  ctr_x;
    c2_t  ctr_y;
    c2_t  x_lo;
    c2_t  x_hi;
    c2_t  y_lo;
    c2_t  y_hi;
  } rbp_item_t;

  // Rounds (k + f) / 2 half away from zero, where frac says the fraction f is nonzero.
  function automatic wide_t round_half(wide_t k, logic frac);
    wide_t r;
    if (!k[0]) begin
      r = k >>> 1;
    end else if (!k[KW-1] || frac) begin
      r = (k + wide_t'(1)) >>> 1;
    end else begin
      r = (k - wide_t'(1)) >>> 1;
    end
    return r;
  endfunction

endpackage

FILE: rtl/rbp_front.sv
module rbp_front import rbp_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic signed [CoordBits-1:0] rect_x_i,
  input  logic signed [CoordBits-1:0] rect_y_i,
  input  size_t                       rect_w_i,
  input  size_t                       rect_h_i,
  input  logic signed [CoordBits-1:0] target_x_i,
  input  logic signed [CoordBits-1:0] target_y_i,
  output logic                        valid_o,
  output rbp_item_t                   item_o,
  output prod_t                       dividend_o,
  output mag_t                        divisor_o
);

  // Stage 1: doubled centre.
  logic  v1_q;
  c2_t   x1_q, y1_q, cx1_q, cy1_q;
  size_t w1_q, h1_q;
  logic signed [CoordBits-1:0] tx1_q, ty1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_q  <= c2_t'(rect_x_i);
      y1_q  <= c2_t'(rect_y_i);
      w1_q  <= rect_w_i;
      h1_q  <= rect_h_i;
      tx1_q <= target_x_i;
      ty1_q <= target_y_i;
      cx1_q <= (c2_t'(rect_x_i) <<< 1) + c2_t'({1'b0, rect_w_i}) - c2_t'(1);
      cy1_q <= (c2_t'(rect_y_i) <<< 1) + c2_t'({1'b0, rect_h_i}) - c2_t'(1);
    end
  end

  // Stage 2: ray deltas, magnitudes, bounds and rounded centre.
  logic   v2_q;
  delta_t dx_d, dy_d;
  mag_t   adx2_q, ady2_q;
  logic   dxz2_q, dyz2_q, dxp2_q, dyp2_q, dxn2_q, dyn2_q;
  size_t  w2_q, h2_q, anw2_q, anh2_q;
  logic   nwz2_q, nhz2_q, nwp2_q, nhp2_q;
  c2_t    cx2_q, cy2_q, ctrx2_q, ctry2_q, xlo2_q, xhi2_q, ylo2_q, yhi2_q;

  assign dx_d = (delta_t'(tx1_q) <<< 1) - delta_t'(cx1_q);
  assign dy_d = (delta_t'(ty1_q) <<< 1) - delta_t'(cy1_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      adx2_q  <= dx_d[DW-1] ? mag_t'(-dx_d) : mag_t'(dx_d);
      ady2_q  <= dy_d[DW-1] ? mag_t'(-dy_d) : mag_t'(dy_d);
      dxz2_q  <= (dx_d == '0);
      dyz2_q  <= (dy_d == '0);
      dxp2_q  <= !dx_d[DW-1] && (dx_d != '0);
      dyp2_q  <= !dy_d[DW-1] && (dy_d != '0);
      dxn2_q  <= dx_d[DW-1];
      dyn2_q  <= dy_d[DW-1];
      w2_q    <= w1_q;
      h2_q    <= h1_q;
      anw2_q  <= (w1_q == '0) ? size_t'(1) : w1_q - size_t'(1);
      anh2_q  <= (h1_q == '0) ? size_t'(1) : h1_q - size_t'(1);
      nwz2_q  <= (w1_q == size_t'(1));
      nhz2_q  <= (h1_q == size_t'(1));
      nwp2_q  <= (w1_q > size_t'(1));
      nhp2_q  <= (h1_q > size_t'(1));
      cx2_q   <= cx1_q;
      cy2_q   <= cy1_q;
      ctrx2_q <= c2_t'(round_half(wide_t'(cx1_q), 1'b0));
      ctry2_q <= c2_t'(round_half(wide_t'(cy1_q), 1'b0));
      xlo2_q  <= x1_q;
      xhi2_q  <= x1_q + c2_t'({1'b0, w1_q}) - c2_t'(1);
      ylo2_q  <= y1_q;
      yhi2_q  <= y1_q + c2_t'({1'b0, h1_q}) - c2_t'(1);
    end
  end

  // Stage 3: cross products for the range tests and the parameter compare.
  logic  v3_q;
  prod_t mx3_q, hx3_q, my3_q, wy3_q;
  mag_t  adx3_q, ady3_q;
  logic  dxz3_q, dyz3_q, dxp3_q, dyp3_q, dxn3_q, dyn3_q, nwz3_q, nhz3_q, nwp3_q, nhp3_q;
  c2_t   cx3_q, cy3_q, ctrx3_q, ctry3_q, xlo3_q, xhi3_q, ylo3_q, yhi3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en_i) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx3_q   <= prod_t'(anw2_q) * prod_t'(ady2_q);
      hx3_q   <= prod_t'(h2_q) * prod_t'(adx2_q);
      my3_q   <= prod_t'(anh2_q) * prod_t'(adx2_q);
      wy3_q   <= prod_t'(w2_q) * prod_t'(ady2_q);
      adx3_q  <= adx2_q;
      ady3_q  <= ady2_q;
      dxz3_q  <= dxz2_q;
      dyz3_q  <= dyz2_q;
      dxp3_q  <= dxp2_q;
      dyp3_q  <= dyp2_q;
      dxn3_q  <= dxn2_q;
      dyn3_q  <= dyn2_q;
      nwz3_q  <= nwz2_q;
      nhz3_q  <= nhz2_q;
      nwp3_q  <= nwp2_q;
      nhp3_q  <= nhp2_q;
      cx3_q   <= cx2_q;
      cy3_q   <= cy2_q;
      ctrx3_q <= ctrx2_q;
      ctry3_q <= ctry2_q;
      xlo3_q  <= xlo2_q;
      xhi3_q  <= xhi2_q;
      ylo3_q  <= ylo2_q;
      yhi3_q  <= yhi2_q;
    end
  end

  // Stage 4: pick the nearest qualifying edge and set up its division.
  logic      v4_q;
  logic      qv, qh;
  rbp_item_t item_d, item4_q;
  prod_t     dvd_d, dvd4_q;
  mag_t      dvs_d, dvs4_q;

  always_comb begin
    qv = !dxz3_q && !nwz3_q && (mx3_q <= hx3_q);
    qh = !dyz3_q && !nhz3_q && (my3_q <= wy3_q) && (!qv || (my3_q < mx3_q));
    item_d.center_only = dxz3_q && dyz3_q;
    item_d.have        = qv || qh;
    item_d.div_to_x    = qh;
    item_d.neg         = qh ? dxn3_q : dyn3_q;
    item_d.base        = qh ? cx3_q : cy3_q;
    if (qh) begin
      item_d.edge_pos = (nhp3_q == dyp3_q) ? yhi3_q : ylo3_q;
    end else begin
      item_d.edge_pos = (nwp3_q == dxp3_q) ? xhi3_q : xlo3_q;
    end
    item_d.ctr_x = ctrx3_q;
    item_d.ctr_y = ctry3_q;
    item_d.x_lo  = xlo3_q;
    item_d.x_hi  = xhi3_q;
    item_d.y_lo  = ylo3_q;
    item_d.y_hi  = yhi3_q;
    dvd_d = qh ? my3_q : mx3_q;
    dvs_d = qh ? ady3_q : adx3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en_i) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item4_q <= item_d;
      dvd4_q  <= dvd_d;
      dvs4_q  <= dvs_d;
    end
  end

  assign valid_o    = v4_q;
  assign item_o     = item4_q;
  assign dividend_o = dvd4_q;
  assign divisor_o  = dvs4_q;

endmodule

FILE: rtl/rbp_div.sv
module rbp_div import rbp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  rbp_item_t         item_i,
  input  prod_t             dividend_i,
  input  mag_t              divisor_i,
  output logic              valid_o,
  output rbp_item_t         item_o,
  output logic [QBits-1:0]  quot_o,
  output logic              rem_nz_o
);

  // One quotient bit per stage, most significant first. The quotient of a
  // qualifying crossing always fits in QBits bits.
  logic              v_q    [QBits];
  prod_t             rem_q  [QBits];
  mag_t              dvs_q  [QBits];
  logic [QBits-1:0]  quot_q [QBits];
  rbp_item_t         item_q [QBits];

  for (genvar j = 0; j < QBits; j++) begin : g_stage
    logic             v_in;
    prod_t            rem_in, cand;
    mag_t             dvs_in;
    logic [QBits-1:0] quot_in;
    rbp_item_t        item_in;
    logic             ge;

    if (j == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = dividend_i;
      assign dvs_in  = divisor_i;
      assign quot_in = '0;
      assign item_in = item_i;
    end else begin : g_next
      assign v_in    = v_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign dvs_in  = dvs_q[j-1];
      assign quot_in = quot_q[j-1];
      assign item_in = item_q[j-1];
    end

    // Trial subtraction of the shifted divisor.
    assign cand = prod_t'(dvs_in) << (QBits - 1 - j);
    assign ge   = (rem_in >= cand);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= ge ? rem_in - cand : rem_in;
        dvs_q[j]  <= dvs_in;
        item_q[j] <= item_in;
        quot_q[j] <= quot_in | (ge ? (QBits'(1) << (QBits - 1 - j)) : '0);
      end
    end
  end

  assign valid_o  = v_q[QBits-1];
  assign item_o   = item_q[QBits-1];
  assign quot_o   = quot_q[QBits-1];
  assign rem_nz_o = (rem_q[QBits-1] != '0);

endmodule

FILE: rtl/rbp_back.sv
module rbp_back import rbp_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  rbp_item_t                   item_i,
  input  logic [QBits-1:0]            quot_i,
  input  logic                        rem_nz_i,
  output logic                        valid_o,
  output logic signed [CoordBits-1:0] border_x_o,
  output logic signed [CoordBits-1:0] border_y_o
);

  // Stage 1: floor quotient, add to the doubled base, round, place the edge.
  wide_t qs, a, k, r, px_d, py_d;
  logic  v1_q, ctr1_q;
  wide_t px1_q, py1_q;
  c2_t   xlo1_q, xhi1_q, ylo1_q, yhi1_q;

  always_comb begin
    qs = wide_t'({1'b0, quot_i});
    if (item_i.neg) begin
      a = -qs - (rem_nz_i ? wide_t'(1) : wide_t'(0));
    end else begin
      a = qs;
    end
    k = wide_t'(item_i.base) + a;
    r = round_half(k, rem_nz_i);
    if (item_i.have && item_i.div_to_x) begin
      px_d = r;
      py_d = wide_t'(item_i.edge_pos);
    end else if (item_i.have) begin
      px_d = wide_t'(item_i.edge_pos);
      py_d = r;
    end else begin
      px_d = wide_t'(item_i.ctr_x);
      py_d = wide_t'(item_i.ctr_y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctr1_q <= item_i.center_only;
      px1_q  <= px_d;
      py1_q  <= py_d;
      xlo1_q <= item_i.x_lo;
      xhi1_q <= item_i.x_hi;
      ylo1_q <= item_i.y_lo;
      yhi1_q <= item_i.y_hi;
    end
  end

  // Stage 2: clamp into the rectangle unless centre-only, the high bound winning, and wrap.
  wide_t tx, ty;
  logic  v2_q;
  logic signed [CoordBits-1:0] bx2_q, by2_q;

  always_comb begin
    tx = px1_q;
    ty = py1_q;
    if (!ctr1_q) begin
      if (tx < wide_t'(xlo1_q)) tx = wide_t'(xlo1_q);
      if (tx > wide_t'(xhi1_q)) tx = wide_t'(xhi1_q);
      if (ty < wide_t'(ylo1_q)) ty = wide_t'(ylo1_q);
      if (ty > wide_t'(yhi1_q)) ty = wide_t'(yhi1_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bx2_q <= tx[CoordBits-1:0];
      by2_q <= ty[CoordBits-1:0];
    end
  end

  assign valid_o    = v2_q;
  assign border_x_o = bx2_q;
  assign border_y_o = by2_q;

endmodule

FILE: rtl/rect_border_point.sv
// Channel   Direction  Width  Contents
// s_axis    in         88     rect_x, rect_y, rect_w, rect_h, target_x, target_y
// m_axis    out        32     border_x, border_y
//
// One query is taken every cycle unless the pipeline is stalled; each result
// passes 4 setup, 12 divider (one quotient bit each) and 2 output stages.
// Reset clears only the stage valid bits. A stall on m_axis freezes the whole
// pipeline in place, and s_axis_tready drops while the output register holds
// an untaken result.
module rect_border_point import rbp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // rect_x[15:0], rect_y[31:16], rect_w[43:32], rect_h[55:44],
  // target_x[71:56], target_y[87:72]
  input  logic [87:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // border_x[15:0], border_y[31:16]
  output logic [31:0] m_axis_tdata
);

  logic      en;
  logic      fv, dv, ov;
  rbp_item_t fitem, ditem;
  prod_t     dvd;
  mag_t      dvs;
  logic [QBits-1:0] quot;
  logic      rem_nz;
  logic signed [CoordBits-1:0] bx, by;

  // The pipeline moves whenever the output register is empty or being taken.
  assign en            = !ov || m_axis_tready;
  assign s_axis_tready = en;

  rbp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (s_axis_tvalid),
    .rect_x_i   (s_axis_tdata[15:0]),
    .rect_y_i   (s_axis_tdata[31:16]),
    .rect_w_i   (s_axis_tdata[43:32]),
    .rect_h_i   (s_axis_tdata[55:44]),
    .target_x_i (s_axis_tdata[71:56]),
    .target_y_i (s_axis_tdata[87:72]),
    .valid_o    (fv),
    .item_o     (fitem),
    .dividend_o (dvd),
    .divisor_o  (dvs)
  );

  rbp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (fv),
    .item_i     (fitem),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .valid_o    (dv),
    .item_o     (ditem),
    .quot_o     (quot),
    .rem_nz_o   (rem_nz)
  );

  rbp_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (dv),
    .item_i     (ditem),
    .quot_i     (quot),
    .rem_nz_i   (rem_nz),
    .valid_o    (ov),
    .border_x_o (bx),
    .border_y_o (by)
  );

  assign m_axis_tvalid = ov;
  assign m_axis_tdata  = {by, bx};

endmodule

FILE: rtl/rbp_checker.sv
module rbp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its data.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // With the output register empty the block always takes input.
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input refused with empty output");

  // A stalled output freezes the input side.
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken during output stall");

endmodule

bind rect_border_point rbp_checker u_rbp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
